>>> hdl/fmtsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtsm_pkg
// Shared types and codes for the folded multi-term substring matcher.
// ----------------------------------------------------------------------------
package fmtsm_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] REQ_TERM_BYTE = 2'd0;
   localparam logic [1:0] REQ_TERM_LEN  = 2'd1;
   localparam logic [1:0] REQ_NAME_BYTE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   // per-cycle controls broadcast to every cell of the row
   typedef struct packed {
      logic byte_we;   // term byte write, cell checks its own position
      logic vec_we;    // match bit write at the shared write address
      logic vec_clr;   // write zero instead of the computed bit
      logic first;     // first folded byte of a name: old match bits read as zero
   } cell_ctrl_type;

endpackage

>>> hdl/fmtsm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtsm_cell
// One character position of all terms: term byte column, match bit column,
// and the shift-and step that takes the neighbor's old bit.
// ----------------------------------------------------------------------------
module fmtsm_cell #(
   parameter int NUM_TERMS    = 512,
   parameter int MAX_TERM_LEN = 32,
   parameter int POS          = 0
) (
   input  logic                                   clock,
   input  fmtsm_pkg::cell_ctrl_type               ctrl,
   input  logic [(NUM_TERMS > 1 ? $clog2(NUM_TERMS) : 1)-1:0] wr_addr,
   input  logic [(NUM_TERMS > 1 ? $clog2(NUM_TERMS) : 1)-1:0] rd_addr,
   input  logic [4:0]                             wr_pos,
   input  logic [7:0]                             wr_byte,
   input  logic [7:0]                             fold,
   input  logic [$clog2(MAX_TERM_LEN + 1)-1:0]    len,
   input  logic                                   prev_in,
   output logic                                   prev_out,
   output logic                                   hit
);

   logic [7:0] byte_mem [NUM_TERMS];
   logic       vec_mem  [NUM_TERMS];

   logic [7:0] byte_rd_ff;
   logic       vec_rd_ff;
   logic       new_bit;
   logic       pos_sel;

   assign pos_sel  = (32'(wr_pos) == POS);
   assign prev_out = ctrl.first ? 1'b0 : vec_rd_ff;
   assign new_bit  = prev_in && (byte_rd_ff == fold) && (32'(len) > POS);
   assign hit      = new_bit && (32'(len) == POS + 1);

   always_ff @(posedge clock) begin
      if (ctrl.byte_we && pos_sel) begin
         byte_mem[wr_addr] <= wr_byte;
      end
      byte_rd_ff <= byte_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.vec_we) begin
         vec_mem[wr_addr] <= ctrl.vec_clr ? 1'b0 : new_bit;
      end
      vec_rd_ff <= vec_mem[rd_addr];
   end

endmodule

>>> hdl/folded_multi_term_substring_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// folded_multi_term_substring_match
// Term table load and folded name streaming; a row of cells, one per term
// character position, sweeps all term slots for each folded name byte.
// ----------------------------------------------------------------------------
// Load items and dropped non-last name bytes are taken in the idle state. A name
// byte that folds to a character is accepted, then swept through the cell
// memories one term slot per cycle, then the registered reads drain in a flush
// state. A last byte then passes through an emit state that raises the result;
// a last byte that folds to nothing goes straight to emit. Emit waits while
// an earlier result is held. Reset first clears the length of every term slot.
module folded_multi_term_substring_match #(
   parameter int NUM_TERMS    = 512,
   parameter int MAX_TERM_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // term_slot[8:0], char_pos[13:9], byte_value[21:14],
                                   // term_length[27:22], zero[31:28]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // denied[0], zero[7:1]
);

   localparam int ADDR_W = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
   localparam int LEN_W  = $clog2(MAX_TERM_LEN + 1);
   localparam int WIDE_W = ADDR_W + 9;

   function automatic logic [7:0] fold_lookup(input logic [7:0] b);
      logic [7:0] f;
      case (b)
         "0":     f = "o";
         "1":     f = "i";
         "3":     f = "e";
         "4":     f = "a";
         "5":     f = "s";
         "7":     f = "t";
         "@":     f = "a";
         "$":     f = "s";
         "!":     f = "i";
         "+":     f = "t";
         default: begin
            if (b >= "A" && b <= "Z") begin
               f = b + 8'd32;
            end else if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
               f = b;
            end else begin
               f = 8'd0;
            end
         end
      endcase
      return f;
   endfunction

   // request fields
   logic [8:0]        term_slot;
   logic [4:0]        char_pos;
   logic [7:0]        byte_value;
   logic [5:0]        term_length;
   logic [1:0]        req_type;
   logic [WIDE_W-1:0] slot_wide;
   logic [ADDR_W-1:0] slot_idx;
   logic              slot_ok;
   logic              pos_ok;
   logic [LEN_W-1:0]  len_sat;
   logic [7:0]        fold_now;
   logic              req_fire;

   assign term_slot   = req_tdata[8:0];
   assign char_pos    = req_tdata[13:9];
   assign byte_value  = req_tdata[21:14];
   assign term_length = req_tdata[27:22];
   assign req_type    = req_tuser;
   assign slot_wide   = WIDE_W'(term_slot);
   assign slot_idx    = slot_wide[ADDR_W-1:0];
   assign slot_ok     = (32'(term_slot) < NUM_TERMS);
   assign pos_ok      = (32'(char_pos) < MAX_TERM_LEN);
   assign len_sat     = (32'(term_length) > MAX_TERM_LEN) ? LEN_W'(MAX_TERM_LEN)
                                                         : LEN_W'(term_length);
   assign fold_now    = fold_lookup(byte_value);
   assign req_fire    = req_tvalid && req_tready;

   // state
   fmtsm_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] upd_idx_ff;
   logic              upd_vld_ff;
   logic [7:0]        fold_ff, fold_in;
   logic              last_ff, last_in;
   logic              hit_ff, hit_in;
   logic              first_ff, first_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              denied_ff, denied_in;
   logic              idx_end;
   logic              emit_go;

   // length table
   logic [LEN_W-1:0]  len_mem [NUM_TERMS];
   logic [LEN_W-1:0]  len_rd_ff;
   logic              len_we;
   logic [ADDR_W-1:0] len_waddr;
   logic [LEN_W-1:0]  len_wdata;

   // cell row
   fmtsm_pkg::cell_ctrl_type   ctrl;
   logic [ADDR_W-1:0]          cell_waddr;
   logic [MAX_TERM_LEN:0]      carry;
   logic [MAX_TERM_LEN-1:0]    cell_hit;

   assign idx_end = (idx_ff == ADDR_W'(NUM_TERMS - 1));
   assign emit_go = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fmtsm_pkg::ST_CLEAR: begin
            if (idx_end) state_in = fmtsm_pkg::ST_IDLE;
         end
         fmtsm_pkg::ST_IDLE: begin
            if (req_fire && req_type == fmtsm_pkg::REQ_NAME_BYTE) begin
               if (fold_now != 8'd0) begin
                  state_in = fmtsm_pkg::ST_SWEEP;
               end else if (req_tlast) begin
                  state_in = fmtsm_pkg::ST_EMIT;
               end
            end
         end
         fmtsm_pkg::ST_SWEEP: begin
            if (idx_end) state_in = fmtsm_pkg::ST_FLUSH;
         end
         fmtsm_pkg::ST_FLUSH: begin
            state_in = last_ff ? fmtsm_pkg::ST_EMIT : fmtsm_pkg::ST_IDLE;
         end
         fmtsm_pkg::ST_EMIT: begin
            if (emit_go) state_in = fmtsm_pkg::ST_IDLE;
         end
         default: state_in = fmtsm_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready    = 1'b0;
      len_we        = 1'b0;
      len_waddr     = idx_ff;
      len_wdata     = '0;
      ctrl.byte_we  = 1'b0;
      ctrl.vec_we   = upd_vld_ff;
      ctrl.vec_clr  = 1'b0;
      ctrl.first    = first_ff;
      cell_waddr    = upd_idx_ff;
      unique case (state_ff)
         fmtsm_pkg::ST_CLEAR: begin
            len_we = 1'b1;
         end
         fmtsm_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cell_waddr   = slot_idx;
            len_waddr    = slot_idx;
            len_wdata    = len_sat;
            ctrl.vec_clr = 1'b1;
            if (req_fire && slot_ok) begin
               ctrl.byte_we = (req_type == fmtsm_pkg::REQ_TERM_BYTE) && pos_ok;
               len_we       = (req_type == fmtsm_pkg::REQ_TERM_LEN);
               // a new length restarts that slot's match bits
               ctrl.vec_we  = (req_type == fmtsm_pkg::REQ_TERM_LEN);
            end
         end
         fmtsm_pkg::ST_SWEEP, fmtsm_pkg::ST_FLUSH, fmtsm_pkg::ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      idx_in       = idx_ff;
      fold_in      = fold_ff;
      last_in      = last_ff;
      hit_in       = hit_ff || (upd_vld_ff && (|cell_hit));
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      denied_in    = denied_ff;
      case (state_ff)
         fmtsm_pkg::ST_CLEAR, fmtsm_pkg::ST_SWEEP: begin
            idx_in = idx_ff + ADDR_W'(1);
         end
         fmtsm_pkg::ST_IDLE: begin
            idx_in  = '0;
            fold_in = fold_now;
            last_in = req_tlast;
         end
         fmtsm_pkg::ST_FLUSH: begin
            first_in = 1'b0;
         end
         fmtsm_pkg::ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               denied_in    = hit_ff;
               hit_in       = 1'b0;
               first_in     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmtsm_pkg::ST_CLEAR;
         idx_ff       <= '0;
         upd_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         upd_vld_ff   <= (state_ff == fmtsm_pkg::ST_SWEEP);
         hit_ff       <= hit_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_idx_ff <= idx_ff;
      fold_ff    <= fold_in;
      last_ff    <= last_in;
      denied_ff  <= denied_in;
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rd_ff <= len_mem[idx_ff];
   end

   // position 0 always starts a match
   assign carry[0] = 1'b1;

   for (genvar k = 0; k < MAX_TERM_LEN; k++) begin : g_cell
      fmtsm_cell #(
         .NUM_TERMS    (NUM_TERMS),
         .MAX_TERM_LEN (MAX_TERM_LEN),
         .POS          (k)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .wr_addr  (cell_waddr),
         .rd_addr  (idx_ff),
         .wr_pos   (char_pos),
         .wr_byte  (byte_value),
         .fold     (fold_ff),
         .len      (len_rd_ff),
         .prev_in  (carry[k]),
         .prev_out (carry[k+1]),
         .hit      (cell_hit[k])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, denied_ff};

   // checks
   a_ready_no_update: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !upd_vld_ff)
      else $error("update in flight while accepting items");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fmtsm_pkg::ST_EMIT))
      else $error("result raised outside emit");

   a_flush_after_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmtsm_pkg::ST_FLUSH) |-> $past(state_ff == fmtsm_pkg::ST_SWEEP))
      else $error("flush without sweep");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmtsm_pkg::ST_EMIT && !rsp_valid_ff) |=> (!hit_ff && first_ff))
      else $error("match state not cleared after result");

endmodule

>>> dv/folded_multi_term_substring_match_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// folded_multi_term_substring_match_tb
// Loads term tables and streams names through the matcher. Each accepted
// item is applied to a local model of the term table and the per-term shift
// vectors. Each name's denial flag is queued and checked in order against the
// result stream. Both sides idle and stall at random unless a test turns it off.
// ----------------------------------------------------------------------------
module folded_multi_term_substring_match_tb;

   localparam int NUM_TERMS    = 512;
   localparam int TERM_LEN     = 32;
   localparam int SWEEP_CYCLES = NUM_TERMS + 2;
   localparam int LIMIT_CYCLES = 4_000_000;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam logic [7:0] DROPPED_CHAR = 8'h00;

   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] slot;
      logic [4:0] pos;
      logic [7:0] value;
      logic [5:0] len;
      logic       last;
   } matcher_req_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // term_slot, char_pos, byte_value, term_length, zero
   logic [1:0]  req_tuser  = '0;  // req_type
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // denied, zero

   // local copy of the matcher state
   logic [7:0]  term_chars  [NUM_TERMS][TERM_LEN];
   logic [31:0] term_loaded [NUM_TERMS];
   logic [5:0]  term_lens   [NUM_TERMS];
   logic [31:0] shift_vec   [NUM_TERMS];
   bit          name_hit;
   bit          denial_q[$];

   // slots that stimulus keeps enabled
   int          live_slots[$];
   bit          in_pool [NUM_TERMS];

   int unsigned fail_count;
   int unsigned items_sent;
   int unsigned cycle_count;
   int          stall_left;
   bit          sender_no_gaps;
   bit          sink_no_stall;

   folded_multi_term_substring_match #(
      .NUM_TERMS   (NUM_TERMS),
      .MAX_TERM_LEN(TERM_LEN)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, denial_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   function automatic logic [7:0] fold_lookup(logic [7:0] b);
      case (b)
         "0": return "o";
         "1": return "i";
         "3": return "e";
         "4": return "a";
         "5": return "s";
         "7": return "t";
         "@": return "a";
         "$": return "s";
         "!": return "i";
         "+": return "t";
         default: ;
      endcase
      if (b >= "A" && b <= "Z") return b + 8'd32;
      if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) return b;
      return DROPPED_CHAR;
   endfunction

   function automatic void predict_item(matcher_req_type r);
      logic [7:0]  f;
      logic [31:0] eq;
      int          tl;
      case (r.kind)
         fmtsm_pkg::REQ_TERM_BYTE: begin
            term_chars[r.slot][r.pos] = r.value;
            term_loaded[r.slot][r.pos] = 1'b1;
         end
         fmtsm_pkg::REQ_TERM_LEN: begin
            term_lens[r.slot] = (r.len > TERM_LEN) ? 6'(TERM_LEN) : r.len;
            shift_vec[r.slot] = '0;
         end
         fmtsm_pkg::REQ_NAME_BYTE: begin
            f = fold_lookup(r.value);
            if (f != DROPPED_CHAR) begin
               for (int t = 0; t < NUM_TERMS; t++) begin
                  tl = int'(term_lens[t]);
                  if (tl == 0) continue;
                  eq = '0;
                  for (int k = 0; k < tl; k++)
                     if (term_chars[t][k] == f) eq[k] = 1'b1;
                  shift_vec[t] = ((shift_vec[t] << 1) | 32'd1) & eq;
                  if (shift_vec[t][tl-1]) name_hit = 1'b1;
               end
            end
            if (r.last) begin
               denial_q = {denial_q, name_hit};
               name_hit = 1'b0;
               foreach (shift_vec[t]) shift_vec[t] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      if (sender_no_gaps) return 0;
      case ($urandom_range(0, 19))
         0:             return int'($urandom_range(10, 40));
         1, 2, 3, 4, 5: return int'($urandom_range(1, 3));
         default:       return 0;
      endcase
   endfunction

   function automatic matcher_req_type random_req();
      matcher_req_type r;
      r.kind  = 2'($urandom_range(0, 3));
      r.slot  = 9'($urandom_range(0, NUM_TERMS - 1));
      r.pos   = 5'($urandom_range(0, TERM_LEN - 1));
      r.value = 8'($urandom_range(0, 255));
      r.len   = 6'($urandom_range(0, 63));
      r.last  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // characters that can come out of the folding step
   function automatic logic [7:0] random_folded();
      int i;
      i = int'($urandom_range(0, 29));
      case (i)
         26:      return "2";
         27:      return "6";
         28:      return "8";
         29:      return "9";
         default: return 8'("a" + i);
      endcase
   endfunction

   // a raw byte that folds to f
   function automatic logic [7:0] disguise(logic [7:0] f);
      int pick;
      pick = int'($urandom_range(0, 3));
      case (f)
         "o": if (pick == 0) return "0";
         "i": if (pick == 0) return "1"; else if (pick == 1) return "!";
         "e": if (pick == 0) return "3";
         "a": if (pick == 0) return "4"; else if (pick == 1) return "@";
         "s": if (pick == 0) return "5"; else if (pick == 1) return "$";
         "t": if (pick == 0) return "7"; else if (pick == 1) return "+";
         default: ;
      endcase
      if (f >= "a" && f <= "z" && pick == 3) return f - 8'd32;
      return f;
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (fold_lookup(b) != DROPPED_CHAR);
      return b;
   endfunction

   // biased toward characters of enabled terms so partial matches are common
   function automatic logic [7:0] near_char();
      int s;
      if (live_slots.size() > 0 && $urandom_range(0, 99) < 60) begin
         s = live_slots[$urandom_range(0, live_slots.size() - 1)];
         if (term_lens[s] != 0)
            return disguise(term_chars[s][$urandom_range(0, term_lens[s] - 1)]);
      end
      return disguise(random_folded());
   endfunction

   task automatic send_item(matcher_req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {4'b0, r.len, r.value, r.pos, r.slot};
      req_tlast  <= r.last;
      do @(posedge clock); while (!req_tready);
      predict_item(r);
      if (r.kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic write_char(int slot, int pos, logic [7:0] v);
      matcher_req_type r;
      r = random_req();
      r.kind  = fmtsm_pkg::REQ_TERM_BYTE;
      r.slot  = 9'(slot);
      r.pos   = 5'(pos);
      r.value = v;
      send_item(r);
   endtask

   // fills unwritten positions first so a sweep never reads an empty cell
   task automatic set_length(int slot, int len);
      matcher_req_type r;
      int eff;
      eff = (len > TERM_LEN) ? TERM_LEN : len;
      for (int p = 0; p < eff; p++)
         if (!term_loaded[slot][p]) write_char(slot, p, random_folded());
      r = random_req();
      r.kind = fmtsm_pkg::REQ_TERM_LEN;
      r.slot = 9'(slot);
      r.len  = 6'(len);
      send_item(r);
      if (len > 0 && !in_pool[slot]) begin
         in_pool[slot] = 1'b1;
         live_slots = {live_slots, slot};
      end
   endtask

   task automatic load_term(int slot, int len);
      int eff;
      eff = (len > TERM_LEN) ? TERM_LEN : len;
      for (int p = 0; p < eff; p++) write_char(slot, p, random_folded());
      set_length(slot, len);
   endtask

   task automatic send_name_char(logic [7:0] b, logic last);
      matcher_req_type r;
      r = random_req();
      r.kind  = fmtsm_pkg::REQ_NAME_BYTE;
      r.value = b;
      r.last  = last;
      send_item(r);
   endtask

   task automatic retire_terms();
      foreach (live_slots[i]) set_length(live_slots[i], 0);
      live_slots.delete();
      foreach (in_pool[s]) in_pool[s] = 1'b0;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (denial_q.size() != 0);
   endtask

   // noise, an optional embedded term, noise; loads may land inside the name
   task automatic send_random_name(int embed_pct);
      logic [7:0] raw[$];
      int         n;
      int         s;
      int         tl;
      n = int'($urandom_range(0, 8));
      repeat (n) raw = {raw, (($urandom_range(0, 9) == 0) ? junk_byte() : near_char())};
      if (live_slots.size() > 0 && $urandom_range(0, 99) < embed_pct) begin
         s  = live_slots[$urandom_range(0, live_slots.size() - 1)];
         tl = int'(term_lens[s]);
         for (int k = 0; k < tl; k++) begin
            if ($urandom_range(0, 9) == 0) raw = {raw, junk_byte()};
            raw = {raw, disguise(term_chars[s][k])};
         end
      end
      n = int'($urandom_range(0, 5));
      repeat (n) raw = {raw, near_char()};
      if (raw.size() == 0 || $urandom_range(0, 7) == 0) raw = {raw, junk_byte()};
      foreach (raw[i]) begin
         if (live_slots.size() > 0 && $urandom_range(0, 24) == 0) begin
            s = live_slots[$urandom_range(0, live_slots.size() - 1)];
            if ($urandom_range(0, 1)) set_length(s, int'(term_lens[s]));
            else write_char(s, int'($urandom_range(0, TERM_LEN - 1)), random_folded());
         end
         send_name_char(raw[i], i == raw.size() - 1);
      end
   endtask

   always @(posedge clock) begin : result_check
      bit want;
      if (rsp_tvalid && rsp_tready) begin
         if (denial_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, denied %0b", rsp_tdata[0]));
         end else begin
            want = denial_q.pop_front();
            if (rsp_tdata[0] !== want)
               report_mismatch($sformatf("denied %0b, expected %0b", rsp_tdata[0], want));
         end
      end
      if (sink_no_stall) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               stall_left = int'($urandom_range(10, 40));
               rsp_tready <= 1'b0;
            end
            1, 2, 3, 4: rsp_tready <= 1'b0;
            default:    rsp_tready <= 1'b1;
         endcase
      end
   end

   task automatic test_directed();
      matcher_req_type r;
      send_name_char("Q", 1'b1);          // no terms loaded
      send_name_char(8'hFF, 1'b1);        // folds to nothing: empty name
      r = '{kind: fmtsm_pkg::REQ_TERM_BYTE, slot: 9'h1FF, pos: 5'h1F, value: 8'hFF,
            len: 6'h3F, last: 1'b1};
      send_item(r);                       // last ignored on loads
      r.kind = REQ_UNUSED;
      send_item(r);
      write_char(0, 0, "i");
      write_char(0, 1, "t");
      set_length(0, 2);
      send_name_char("1", 1'b0);
      send_name_char("+", 1'b1);
      send_name_char("!", 1'b0);
      send_name_char(8'h80, 1'b0);        // dropped byte inside a match
      send_name_char("7", 1'b1);
      send_name_char("I", 1'b0);
      set_length(0, 2);                   // clears the partial match
      send_name_char("T", 1'b1);
      send_name_char("1", 1'b0);
      send_name_char("T", 1'b0);
      send_name_char("%", 1'b1);          // dropped last byte still ends the name
      set_length(0, 0);
      send_name_char("1", 1'b0);
      send_name_char("7", 1'b1);
      write_char(256, 0, "9");
      set_length(256, 1);
      send_name_char("9", 1'b1);
   endtask

   task automatic test_long_terms();
      int goal;
      retire_terms();
      load_term(NUM_TERMS - 1, TERM_LEN);
      load_term(int'($urandom_range(1, NUM_TERMS - 2)),
                int'($urandom_range(TERM_LEN + 1, 63)));
      load_term(0, TERM_LEN - 1);
      goal = items_sent + 150;
      while (items_sent < goal) send_random_name(80);
   endtask

   task automatic test_random_traffic();
      matcher_req_type r;
      int goal;
      int s;
      retire_terms();
      repeat (4) load_term(int'($urandom_range(0, NUM_TERMS - 1)),
                           int'($urandom_range(2, 5)));
      goal = items_sent + 700;
      while (items_sent < goal) begin
         case ($urandom_range(0, 19))
            0: load_term(int'($urandom_range(0, NUM_TERMS - 1)),
                         ($urandom_range(0, 7) == 0) ? int'($urandom_range(6, 63))
                                                     : int'($urandom_range(1, 5)));
            1: if (live_slots.size() > 0) begin
               s = live_slots[$urandom_range(0, live_slots.size() - 1)];
               set_length(s, ($urandom_range(0, 1)) ? 0 : int'($urandom_range(1, 4)));
            end
            2: begin
               // stray item; a length goes through the fill of unwritten bytes
               r = random_req();
               if (r.kind == fmtsm_pkg::REQ_TERM_LEN) set_length(int'(r.slot), int'(r.len));
               else send_item(r);
            end
            default: send_random_name(50);
         endcase
      end
   endtask

   task automatic test_noise();
      matcher_req_type r;
      int goal;
      goal = items_sent + 150;
      while (items_sent < goal) begin
         r = random_req();
         case (r.kind)
            fmtsm_pkg::REQ_TERM_LEN: begin
               if (live_slots.size() > 0 && $urandom_range(0, 3) != 0)
                  r.slot = 9'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
               set_length(int'(r.slot), int'(r.len));
            end
            fmtsm_pkg::REQ_NAME_BYTE: begin
               r.last = ($urandom_range(0, 5) == 0);
               send_item(r);
            end
            default: send_item(r);
         endcase
      end
   endtask

   task automatic test_drain_pauses();
      retire_terms();
      repeat (3) load_term(int'($urandom_range(0, NUM_TERMS - 1)),
                           int'($urandom_range(2, 4)));
      repeat (8) begin
         send_random_name(60);
         wait_for_results();
      end
   endtask

   initial begin
      foreach (term_loaded[s]) begin
         term_loaded[s] = '0;
         term_lens[s]   = '0;
         shift_vec[s]   = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      sender_no_gaps = 1'b0;
      sink_no_stall  = 1'b0;
      test_directed();

      sender_no_gaps = 1'b1;
      sink_no_stall  = 1'b1;
      test_long_terms();

      sender_no_gaps = 1'b0;
      sink_no_stall  = 1'b0;
      test_random_traffic();
      test_noise();

      sink_no_stall = 1'b1;
      test_drain_pauses();

      wait_for_results();
      repeat (SWEEP_CYCLES + 8) @(posedge clock);
      if (fail_count == 0 && denial_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
